### rtl/fqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

  // Fraction bits of the sample and scale formats
  localparam int FRAC_BITS = 16;

  localparam int DATA_W  = 32;
  localparam int MODE_W  = 2;
  localparam int QBITS_W = 5;
  localparam int ZP_W    = 8;
  localparam int SHIFT_W = 5;
  localparam int CFG_IDX_W = 3;

  // Quantized code after the clamp, signed, covers -32768 .. 65535
  localparam int QC_W = 18;

  // Divider stages, one quotient bit each
  localparam int DIV_STAGES = DATA_W;

  localparam logic [QBITS_W-1:0] QBITS_MIN = 5'd2;
  localparam logic [QBITS_W-1:0] QBITS_MAX = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SYM    = 2'd0,
    MODE_AFFINE = 2'd1,
    MODE_POW2   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_QBITS = 3'd1,
    REG_SCALE = 3'd2,
    REG_ZP    = 3'd3,
    REG_SHIFT = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/fake_quant_dequant_unit.sv
// Pipeline: an input register, a 32-stage restoring divider (one quotient
//   bit per stage), then round, clamp, multiply and output registers.
// Throughput: one sample per cycle while no result is stalled.
// A stalled result holds the whole pipeline; nothing is dropped.
// Reset (synchronous, rst high) empties the pipeline and loads the registers
//   with mode symmetric, 8 bits, scale 1.0, zero point 0, shift 0.
`timescale 1ns / 1ps
`default_nettype none

module fake_quant_dequant_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fqd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fqd_pkg::DATA_W-1:0]    cfg_data,
  input  wire logic                          sample_valid,
  output      logic                          sample_stall,
  input  wire logic signed [fqd_pkg::DATA_W-1:0] sample,
  input  wire logic                          last,
  output      logic                          result_valid,
  input  wire logic                          result_stall,
  output      logic signed [fqd_pkg::DATA_W-1:0] dequantized,
  output      logic                          last_out
);
  import fqd_pkg::*;

  localparam int PROD_W = QC_W + DATA_W + 1;

  // Configuration registers
  mode_t               mode;
  logic [QBITS_W-1:0]  quant_bits;
  logic [DATA_W-1:0]   scale_value;
  logic [ZP_W-1:0]     zero_offset;
  logic signed [SHIFT_W-1:0] shift_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SYM;
      quant_bits   <= 5'd8;
      scale_value  <= 32'd65536;
      zero_offset  <= '0;
      shift_amount <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode         <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_QBITS: quant_bits   <= cfg_data[QBITS_W-1:0];
        REG_SCALE: scale_value  <= cfg_data;
        REG_ZP:    zero_offset  <= cfg_data[ZP_W-1:0];
        REG_SHIFT: shift_amount <= $signed(cfg_data[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Effective divisor, bit count: user keeps static in flight (unenforced)
  logic [DATA_W-1:0]  den;
  logic [QBITS_W-1:0] bits_eff;
  logic signed [SHIFT_W:0] pow_k;

  always_comb begin
    pow_k = $signed(6'(FRAC_BITS)) + {shift_amount[SHIFT_W-1], shift_amount};
    if (mode == MODE_POW2) begin
      den = DATA_W'(1) << pow_k[4:0];
    end else if (scale_value == '0) begin
      den = DATA_W'(1);
    end else begin
      den = scale_value;
    end
    if (quant_bits < QBITS_MIN) begin
      bits_eff = QBITS_MIN;
    end else if (quant_bits > QBITS_MAX) begin
      bits_eff = QBITS_MAX;
    end else begin
      bits_eff = quant_bits;
    end
  end

  // Global advance: everything moves unless a result waits
  logic adv;
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  // Divider pipeline: acc shifts dividend out and quotient in
  logic              dv_valid [0:DIV_STAGES];
  logic [DATA_W-1:0] dv_rem   [0:DIV_STAGES];
  logic [DATA_W-1:0] dv_acc   [0:DIV_STAGES];
  logic              dv_neg   [0:DIV_STAGES];
  logic              dv_last  [0:DIV_STAGES];

  // Capture sample magnitude and sign
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]  <= '0;
      dv_acc[0]  <= sample[DATA_W-1] ? DATA_W'(-sample) : DATA_W'(sample);
      dv_neg[0]  <= sample[DATA_W-1];
      dv_last[0] <= last;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [DATA_W:0]   trial;
    logic              take;
    logic [DATA_W:0]   diff;

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
      trial = {dv_rem[g], dv_acc[g][DATA_W-1]};
      diff  = trial - {1'b0, den};
      take  = (trial >= {1'b0, den});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[g+1] <= dv_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[g+1]  <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dv_acc[g+1]  <= {dv_acc[g][DATA_W-2:0], take};
        dv_neg[g+1]  <= dv_neg[g];
        dv_last[g+1] <= dv_last[g];
      end
    end
  end

  // Round half to even and restore sign
  logic                    rd_valid;
  logic signed [DATA_W+1:0] rd_q;
  logic                    rd_last;
  logic                    rd_up;
  logic [DATA_W:0]         rd_mag;

  always_comb begin
    rd_up  = ({dv_rem[DIV_STAGES], 1'b0} > {1'b0, den}) ||
             (({dv_rem[DIV_STAGES], 1'b0} == {1'b0, den}) && dv_acc[DIV_STAGES][0]);
    rd_mag = {1'b0, dv_acc[DIV_STAGES]} + {{DATA_W{1'b0}}, rd_up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (adv) begin
      rd_valid <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q    <= dv_neg[DIV_STAGES] ? -$signed({1'b0, rd_mag}) : $signed({1'b0, rd_mag});
      rd_last <= dv_last[DIV_STAGES];
    end
  end

  // Clamp to the code range, affine mode around the zero point
  logic                   cl_valid;
  logic signed [QC_W-1:0] cl_q;
  logic                   cl_last;
  logic signed [DATA_W+1:0] cl_shi, cl_slo, cl_uhi, cl_zp, cl_t, cl_r;

  always_comb begin
    cl_shi = $signed((DATA_W+2)'(1) << (bits_eff - 5'd1)) - 34'sd1;
    cl_slo = -cl_shi - 34'sd1;
    cl_uhi = $signed((DATA_W+2)'(1) << bits_eff) - 34'sd1;
    cl_zp  = $signed({{(DATA_W+2-ZP_W){1'b0}}, zero_offset});
    cl_t   = rd_q + cl_zp;
    if (mode == MODE_AFFINE) begin
      if (cl_t < 0) begin
        cl_r = -cl_zp;
      end else if (cl_t > cl_uhi) begin
        cl_r = cl_uhi - cl_zp;
      end else begin
        cl_r = rd_q;
      end
    end else begin
      if (rd_q < cl_slo) begin
        cl_r = cl_slo;
      end else if (rd_q > cl_shi) begin
        cl_r = cl_shi;
      end else begin
        cl_r = rd_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_valid <= 1'b0;
    end else if (adv) begin
      cl_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl_q    <= cl_r[QC_W-1:0];
      cl_last <= rd_last;
    end
  end

  // Multiply back by the divisor (the scale, or the power of two in pow2 mode)
  logic                     mu_valid;
  logic signed [PROD_W-1:0] mu_prod;
  logic                     mu_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else if (adv) begin
      mu_valid <= cl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_prod <= PROD_W'(cl_q * $signed({1'b0, den}));
      mu_last <= cl_last;
    end
  end

  // Saturate to 32 bits into the output register
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2147483647);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - 1;
  logic signed [DATA_W-1:0] sat_val;

  always_comb begin
    if (mu_prod > SAT_HI) begin
      sat_val = SAT_HI[DATA_W-1:0];
    end else if (mu_prod < SAT_LO) begin
      sat_val = SAT_LO[DATA_W-1:0];
    end else begin
      sat_val = mu_prod[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= mu_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dequantized <= sat_val;
      last_out    <= mu_last;
    end
  end

  // Checks
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    sample_stall == (result_valid && result_stall))
    else $error("input stall not tied to output backpressure");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    cl_valid |-> (cl_q >= -18'sd32768 - 18'sd255) && (cl_q <= 18'sd65535))
    else $error("clamped code out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !mu_valid) |=> !result_valid)
    else $error("result repeated after delivery");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (adv && mu_valid) |=> result_valid)
    else $error("result lost at output stage");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fqd_pkg::*;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } sample_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [DATA_W-1:0] sample = '0;
  logic last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [DATA_W-1:0] dequantized;
  logic last_out;

  // Local copy of the register file
  mode_t       cur_mode;
  logic [4:0]  cur_qbits;
  logic [31:0] cur_scale;
  logic [7:0]  cur_zp;
  logic signed [4:0] cur_shift;

  sample_beat_t pending_samples[$];
  result_beat_t expected_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  localparam int CYCLE_LIMIT = 900000;

  fake_quant_dequant_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample(sample), .last(last),
    .result_valid(result_valid), .result_stall(result_stall),
    .dequantized(dequantized), .last_out(last_out)
  );

  always #6 clk = ~clk;

  // num / den rounded to nearest, ties to even
  function automatic longint div_round_even(longint num, longint unsigned den);
    bit neg;
    longint unsigned m, q, r;
    neg = num < 0;
    m = neg ? longint'(0) - num : num;
    q = m / den;
    r = m % den;
    if (r > den - r || (r == den - r && q[0])) q++;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [31:0] fake_quantize(logic signed [31:0] s_in);
    longint s, shi, slo, q, res, zp, uhi;
    longint unsigned sc;
    int bits, k;
    s = s_in;
    bits = cur_qbits;
    if (bits < 2) bits = 2;
    if (bits > 16) bits = 16;
    shi = (longint'(1) << (bits - 1)) - 1;
    slo = -shi - 1;
    if (cur_mode == MODE_POW2) begin
      k = FRAC_BITS + int'(cur_shift);
      if (k >= 0) begin
        q = clip(div_round_even(s, longint'(1) << k), slo, shi);
        res = q * (longint'(1) << k);
      end else begin
        q = clip(s * (longint'(1) << (-k)), slo, shi);
        res = div_round_even(q, longint'(1) << (-k));
      end
    end else begin
      sc = (cur_scale != 0) ? cur_scale : 1;
      q = div_round_even(s, sc);
      if (cur_mode == MODE_AFFINE) begin
        zp = cur_zp;
        uhi = (longint'(1) << bits) - 1;
        q = clip(q + zp, 0, uhi) - zp;
      end else begin
        q = clip(q, slo, shi);
      end
      res = q * longint'(sc);
    end
    res = clip(res, -64'sd2147483648, 64'sd2147483647);
    return res[31:0];
  endfunction

  // Driver: present queued beats, predict on acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        expected_results.push_back('{fake_quantize(sample), last});
      end
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_valid <= 1'b1;
          sample <= pending_samples[0].sample;
          last <= pending_samples[0].last;
          pending_samples.pop_front();
        end else begin
          sample_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %0d last %0b", dequantized, last_out);
      end else begin
        if (dequantized !== expected_results[0].value ||
            last_out !== expected_results[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0b actual %0d/%0b",
                     expected_results[0].value, expected_results[0].last,
                     dequantized, last_out);
        end
        expected_results.pop_front();
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fake_quant_dequant_unit");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode = mode_t'(val[1:0]);
      REG_QBITS: cur_qbits = val[4:0];
      REG_SCALE: cur_scale = val;
      REG_ZP:    cur_zp = val[7:0];
      REG_SHIFT: cur_shift = val[4:0];
      default: ;
    endcase
  endtask

  // Wait until every queued beat is accepted and answered, then drain
  task automatic drain_pipeline();
    while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(2000) - 1000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return ($urandom_range(300) - 150) * 32768 + $urandom_range(1) * 32768;
      4: return {$urandom} >> $urandom_range(31);
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic queue_samples(int n);
    for (int i = 0; i < n; i++)
      pending_samples.push_back('{rand_sample(), 1'($urandom_range(1))});
  endtask

  task automatic random_config();
    write_reg(REG_MODE, $urandom_range(3));
    write_reg(REG_QBITS, $urandom_range(4) == 0 ? $urandom_range(31) : $urandom_range(2, 16));
    case ($urandom_range(3))
      0: write_reg(REG_SCALE, $urandom_range(1) ? 0 : $urandom_range(1, 4));
      1: write_reg(REG_SCALE, $urandom);
      default: write_reg(REG_SCALE, $urandom_range(1 << 21, 1 << 9));
    endcase
    write_reg(REG_ZP, $urandom_range(255));
    write_reg(REG_SHIFT, $urandom_range(31));
  endtask

  initial begin
    cur_mode = MODE_SYM;
    cur_qbits = 8;
    cur_scale = 32'd65536;
    cur_zp = 0;
    cur_shift = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and rounding ties at reset settings
    pending_samples.push_back('{32'sh8000_0000, 1'b0});
    pending_samples.push_back('{32'sh7FFF_FFFF, 1'b1});
    pending_samples.push_back('{32'sh0000_8000, 1'b0});
    pending_samples.push_back('{32'sh0001_8000, 1'b1});
    pending_samples.push_back('{-32'sh0000_8000, 1'b0});
    pending_samples.push_back('{32'sh0000_0000, 1'b1});
    pending_samples.push_back('{-32'sd1, 1'b0});
    drain_pipeline();

    // Directed: affine with top zero point, widest bits
    write_reg(REG_MODE, MODE_AFFINE);
    write_reg(REG_QBITS, 16);
    write_reg(REG_ZP, 255);
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    pending_samples.push_back('{32'sh8000_0000, 1'b1});
    pending_samples.push_back('{32'sh7FFF_FFFF, 1'b0});
    drain_pipeline();
    write_reg(REG_SCALE, 0);
    pending_samples.push_back('{32'sh7FFF_FFFF, 1'b1});
    pending_samples.push_back('{32'sh8000_0000, 1'b0});
    drain_pipeline();

    // Directed: power-of-two at both shift extremes, unused mode, bit count out of range
    write_reg(REG_MODE, MODE_POW2);
    write_reg(REG_SHIFT, 5'b10000);
    write_reg(REG_QBITS, 2);
    pending_samples.push_back('{32'sd1, 1'b0});
    pending_samples.push_back('{-32'sd3, 1'b1});
    drain_pipeline();
    write_reg(REG_SHIFT, 5'd15);
    write_reg(REG_QBITS, 31);
    pending_samples.push_back('{32'sh7FFF_FFFF, 1'b0});
    pending_samples.push_back('{32'sh8000_0000, 1'b1});
    drain_pipeline();
    write_reg(REG_MODE, MODE_RSVD);
    write_reg(REG_QBITS, 0);
    write_reg(REG_SCALE, 1);
    pending_samples.push_back('{32'sd5, 1'b0});
    pending_samples.push_back('{-32'sd7, 1'b1});
    drain_pipeline();

    // Random phases over idle and stall patterns
    for (int ph = 0; ph < 26; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      random_config();
      queue_samples(50);
      drain_pipeline();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS fake_quant_dequant_unit");
    end else begin
      $display("FAIL fake_quant_dequant_unit");
    end
    $finish;
  end
endmodule

### sim.f
rtl/fqd_pkg.sv
rtl/fake_quant_dequant_unit.sv
tb/tb.sv
